@@ hdl/smsp_pkg.sv @@
// ----------------------------------------------------------------------------
// smsp_pkg
// Shared types and constants for the shuffled minimal-standard generator.
// ----------------------------------------------------------------------------
package smsp_pkg;

    localparam int VAL_W  = 31;
    localparam int MULT_W = 15;
    localparam int PROD_W = VAL_W + MULT_W;
    localparam int FRAC_W = 24;

    localparam logic [MULT_W-1:0] LCG_MULT     = 15'd16807;
    localparam logic [VAL_W-1:0]  LCG_MOD      = 31'h7FFF_FFFF;
    localparam int                WARMUP_STEPS = 8;
    localparam logic [FRAC_W-1:0] FRACTION_MAX = 24'd16777214;
    localparam logic [FRAC_W-1:0] FRACTION_ALL = 24'hFF_FFFF;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_MUL,
        S_FOLD,
        S_SWAP
    } state_t;

endpackage

@@ hdl/smsp_ram.sv @@
// ----------------------------------------------------------------------------
// smsp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module smsp_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 32,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ hdl/shuffled_minimal_standard_prng.sv @@
// ----------------------------------------------------------------------------
// shuffled_minimal_standard_prng
// Park-Miller generator (x * 16807 mod 2^31-1) behind a Bays-Durham shuffle.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): func = 0 draws a number, func = 1
//   reseeds from seed (0 and 2^31-1 act as 1) and then draws. in_stall is
//   high while an item is being worked on.
//   Output channel (out_valid / out_stall): one beat per input beat with
//   raw_value and fraction (Q0.24, raw_value >> 7, saturated).
//   Steps: a draw finds the table index from a reciprocal estimate plus
//   one correction step, then does one multiply, one mod fold and one table
//   swap; no new item is accepted until the swap is done. A reseed, or the
//   first draw after reset, first runs the warm-up steps and one generator
//   step per table entry to fill the table: every generator step goes
//   through the one shared multiplier and fold stage.
//   Reset sets the generator to 1 and marks the table empty; the table is
//   refilled on the first draw. A stalled result stays in the output
//   register; the next item is accepted meanwhile and waits in its swap
//   step until the output register is free.
// ----------------------------------------------------------------------------
module shuffled_minimal_standard_prng #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          func,
    input  logic [smsp_pkg::VAL_W-1:0]    seed,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [smsp_pkg::VAL_W-1:0]    raw_value,
    output logic [smsp_pkg::FRAC_W-1:0]   fraction
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(smsp_pkg::WARMUP_STEPS + TABLE_DEPTH + 1);
    localparam longint unsigned SHUFFLE_DIV = 1 + (64'd2147483646 / TABLE_DEPTH);
    // index estimate: top 16 bits of the value times 2^35 / SHUFFLE_DIV
    localparam int HI_LSB = 15;
    localparam int RCP_SH = 20;
    localparam int RCP_W  = 11;
    localparam int EST_W  = smsp_pkg::VAL_W - HI_LSB + RCP_W;
    localparam longint unsigned SHUF_RCP = (64'd1 << (HI_LSB + RCP_SH)) / SHUFFLE_DIV;
    localparam logic [RCP_W-1:0]   RCP_K = RCP_W'(SHUF_RCP);
    localparam logic [IDX_W+31:0]  DIV_K = (IDX_W+32)'(SHUFFLE_DIV);
    localparam logic [CNT_W-1:0] FILL_STEPS =
        CNT_W'(smsp_pkg::WARMUP_STEPS + TABLE_DEPTH);
    localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(2);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    smsp_pkg::state_t state_reg, state_next;

    logic [smsp_pkg::VAL_W-1:0]  lcg_reg, lcg_next;
    logic [smsp_pkg::VAL_W-1:0]  last_reg, last_next;
    logic [smsp_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic [smsp_pkg::VAL_W-1:0]  rem_reg, rem_next;
    logic [IDX_W-1:0]            q_reg, q_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic                        fill_reg, fill_next;
    logic                        out_valid_reg, out_valid_next;
    logic [smsp_pkg::VAL_W-1:0]  raw_reg, raw_next;
    logic [smsp_pkg::FRAC_W-1:0] frac_reg, frac_next;

    logic                        in_fire;
    logic                        out_free;
    logic                        need_fill;
    logic [smsp_pkg::VAL_W-1:0]  seed_fixed;
    logic [31:0]                 fold_sum;
    logic [smsp_pkg::VAL_W-1:0]  fold_val;
    logic [EST_W-1:0]            est_prod;
    logic [IDX_W:0]              q_inc;
    logic [IDX_W+31:0]           q_bound;
    logic                        div_ge;
    logic [smsp_pkg::FRAC_W-1:0] frac_raw;

    logic                        wr_en;
    logic [IDX_W-1:0]            wr_addr;
    logic [smsp_pkg::VAL_W-1:0]  wr_data;
    logic [smsp_pkg::VAL_W-1:0]  rd_data;

    smsp_ram #(
        .WIDTH (smsp_pkg::VAL_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (q_reg),
        .rd_data (rd_data)
    );

    assign in_stall  = (state_reg != smsp_pkg::S_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign raw_value = raw_reg;
    assign fraction  = frac_reg;

    assign need_fill  = func || (last_reg == '0);
    assign seed_fixed = ((seed == '0) || (seed == smsp_pkg::LCG_MOD)) ?
                        smsp_pkg::VAL_W'(1) : seed;

    // Mersenne fold: low 31 bits plus high bits, one conditional subtract
    assign fold_sum = {1'b0, prod_reg[smsp_pkg::VAL_W-1:0]}
                    + 32'(prod_reg[smsp_pkg::PROD_W-1:smsp_pkg::VAL_W]);
    assign fold_val = (fold_sum >= {1'b0, smsp_pkg::LCG_MOD}) ?
                      smsp_pkg::VAL_W'(fold_sum - {1'b0, smsp_pkg::LCG_MOD}) :
                      smsp_pkg::VAL_W'(fold_sum);

    // estimate is exact or one low; the compare bumps it when one low
    assign est_prod = EST_W'(rem_reg[smsp_pkg::VAL_W-1:HI_LSB]) * EST_W'(RCP_K);
    assign q_inc    = {1'b0, q_reg} + (IDX_W+1)'(1);
    assign q_bound  = (IDX_W+32)'(q_inc) * DIV_K;
    assign div_ge   = ({{(IDX_W+1){1'b0}}, rem_reg} >= q_bound);
    assign frac_raw = rd_data[smsp_pkg::VAL_W-1:7];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            smsp_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = need_fill ? smsp_pkg::S_MUL : smsp_pkg::S_DIV;
                end
            end
            smsp_pkg::S_DIV:
            begin
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = smsp_pkg::S_MUL;
                end
            end
            smsp_pkg::S_MUL:
            begin
                state_next = smsp_pkg::S_FOLD;
            end
            smsp_pkg::S_FOLD:
            begin
                if (!fill_reg)
                begin
                    state_next = smsp_pkg::S_SWAP;
                end
                else if (cnt_reg == CNT_W'(1))
                begin
                    state_next = smsp_pkg::S_DIV;
                end
                else
                begin
                    state_next = smsp_pkg::S_MUL;
                end
            end
            smsp_pkg::S_SWAP:
            begin
                if (out_free)
                begin
                    state_next = smsp_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = smsp_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        lcg_next       = lcg_reg;
        last_next      = last_reg;
        prod_next      = prod_reg;
        rem_next       = rem_reg;
        q_next         = q_reg;
        cnt_next       = cnt_reg;
        fill_next      = fill_reg;
        out_valid_next = out_valid_reg && out_stall;
        raw_next       = raw_reg;
        frac_next      = frac_reg;
        wr_en          = 1'b0;
        wr_addr        = q_reg;
        wr_data        = lcg_reg;

        case (state_reg)
            smsp_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    if (need_fill)
                    begin
                        lcg_next  = func ? seed_fixed : lcg_reg;
                        cnt_next  = FILL_STEPS;
                        fill_next = 1'b1;
                    end
                    else
                    begin
                        rem_next = last_reg;
                        cnt_next = DIV_STEPS;
                    end
                end
            end
            smsp_pkg::S_DIV:
            begin
                if (cnt_reg == DIV_STEPS)
                begin
                    q_next = IDX_W'(est_prod >> RCP_SH);
                end
                else
                begin
                    q_next = q_reg + IDX_W'(div_ge);
                end
                cnt_next = cnt_reg - CNT_W'(1);
            end
            smsp_pkg::S_MUL:
            begin
                prod_next = smsp_pkg::PROD_W'(lcg_reg)
                          * smsp_pkg::PROD_W'(smsp_pkg::LCG_MULT);
            end
            smsp_pkg::S_FOLD:
            begin
                lcg_next = fold_val;
                if (fill_reg)
                begin
                    // table fills from the top entry down to entry 0
                    if (cnt_reg <= DEPTH_CNT)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = IDX_W'(cnt_reg - CNT_W'(1));
                        wr_data = fold_val;
                    end
                    if (cnt_reg == CNT_W'(1))
                    begin
                        last_next = fold_val;
                        rem_next  = fold_val;
                        cnt_next  = DIV_STEPS;
                        fill_next = 1'b0;
                    end
                    else
                    begin
                        cnt_next = cnt_reg - CNT_W'(1);
                    end
                end
            end
            smsp_pkg::S_SWAP:
            begin
                if (out_free)
                begin
                    wr_en          = 1'b1;
                    last_next      = rd_data;
                    out_valid_next = 1'b1;
                    raw_next       = rd_data;
                    frac_next      = (frac_raw == smsp_pkg::FRACTION_ALL) ?
                                     smsp_pkg::FRACTION_MAX : frac_raw;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= smsp_pkg::S_IDLE;
            lcg_reg       <= smsp_pkg::VAL_W'(1);
            last_reg      <= '0;
            cnt_reg       <= '0;
            fill_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lcg_reg       <= lcg_next;
            last_reg      <= last_next;
            cnt_reg       <= cnt_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        raw_reg  <= raw_next;
        frac_reg <= frac_next;
    end

`ifndef NO_ASSERTIONS
    // a new result only appears right after a table swap
    a_out_from_swap: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == smsp_pkg::S_SWAP))
        else $error("result appeared without a table swap");

    // the generator state must never collapse to zero
    a_lcg_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        lcg_reg != '0)
        else $error("generator state is zero");

    // index division only runs on a filled table
    a_div_filled: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == smsp_pkg::S_DIV) |-> (last_reg != '0 && !fill_reg))
        else $error("index division on an unfilled table");

    // a delivered value always comes from a written table entry
    a_raw_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (raw_reg != '0))
        else $error("result value is zero");
`endif

endmodule

@@ verif/tb_shuffled_minimal_standard_prng.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_shuffled_minimal_standard_prng
// Self-checking bench for the shuffled minimal-standard generator: a short
// stimulus table (first draw after reset, zero and all-ones seeds, a seed
// that drives the fraction into saturation), then random draws and reseeds.
// Every output beat is compared with a built-in predictor of the generator
// and shuffle table, under bursty input and randomly stalled output.
// ----------------------------------------------------------------------------
module tb_shuffled_minimal_standard_prng;

    localparam int TAB_DEPTH    = 32;
    localparam int RAND_N       = 1700;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 2 * (smsp_pkg::WARMUP_STEPS + TAB_DEPTH) + 40;
    localparam int CYCLE_LIMIT  = 1_000_000;

    localparam logic OP_DRAW   = 1'b0;
    localparam logic OP_RESEED = 1'b1;

    localparam bit [31:0] SHUF_DIV = 32'd1 + (32'h7FFF_FFFE / TAB_DEPTH);
    // 16807 * LCG_MULT_INV == 1 mod 2^31-1, used to step the generator back
    localparam bit [31:0] LCG_MULT_INV = 32'd1407677000;
    // raw values from here up give a fraction of all ones before the clamp
    localparam int SAT_RAW_MIN = 2147483520;

    typedef struct packed {
        logic [smsp_pkg::VAL_W-1:0]  raw;
        logic [smsp_pkg::FRAC_W-1:0] frac;
    } draw_t;

    typedef struct packed {
        logic                        fn;
        logic [smsp_pkg::VAL_W-1:0]  sd;
        logic                        use_sat;  // replace sd with the saturating seed
        logic                        chk;      // frac below is the typed-in expectation
        logic [smsp_pkg::FRAC_W-1:0] frac;
    } dir_row_t;

    localparam int DIR_N = 20;
    localparam dir_row_t DIR_ROWS [DIR_N] = '{
        '{OP_DRAW,   31'h0000_0000, 1'b0, 1'b0, 24'h0},  // first draw fills from 1
        '{OP_DRAW,   31'h7FFF_FFFF, 1'b0, 1'b0, 24'h0},  // seed ignored on a draw
        '{OP_DRAW,   31'h2AAA_AAAA, 1'b0, 1'b0, 24'h0},
        '{OP_RESEED, 31'h0000_0000, 1'b0, 1'b0, 24'h0},  // zero seed acts as 1
        '{OP_DRAW,   31'h5555_5555, 1'b0, 1'b0, 24'h0},
        '{OP_RESEED, 31'h7FFF_FFFF, 1'b0, 1'b0, 24'h0},  // all-ones seed acts as 1
        '{OP_DRAW,   31'h0000_0000, 1'b0, 1'b0, 24'h0},
        '{OP_RESEED, 31'h0000_0001, 1'b0, 1'b0, 24'h0},
        '{OP_DRAW,   31'h7FFF_FFFF, 1'b0, 1'b0, 24'h0},
        '{OP_RESEED, 31'h7FFF_FFFE, 1'b0, 1'b0, 24'h0},
        '{OP_DRAW,   31'h0000_0000, 1'b0, 1'b0, 24'h0},
        '{OP_RESEED, 31'h2AAA_AAAA, 1'b0, 1'b0, 24'h0},
        '{OP_RESEED, 31'h5555_5555, 1'b0, 1'b0, 24'h0},
        '{OP_RESEED, 31'h0000_0000, 1'b1, 1'b1, smsp_pkg::FRACTION_MAX},
        '{OP_DRAW,   31'h1234_5678, 1'b0, 1'b0, 24'h0},
        '{OP_DRAW,   31'h6DCB_A987, 1'b0, 1'b0, 24'h0},
        '{OP_RESEED, 31'd16807,     1'b0, 1'b0, 24'h0},
        '{OP_DRAW,   31'h0000_0000, 1'b0, 1'b0, 24'h0},
        '{OP_DRAW,   31'h7FFF_FFFF, 1'b0, 1'b0, 24'h0},
        '{OP_DRAW,   31'h0F0F_0F0F, 1'b0, 1'b0, 24'h0}
    };

    logic                        clk       = 1'b0;
    logic                        rst_n     = 1'b0;
    logic                        in_valid  = 1'b0;
    logic                        in_stall;
    logic                        func      = 1'b0;
    logic [smsp_pkg::VAL_W-1:0]  seed      = '0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic [smsp_pkg::VAL_W-1:0]  raw_value;
    logic [smsp_pkg::FRAC_W-1:0] fraction;

    // predictor state
    logic [smsp_pkg::VAL_W-1:0] gen_state = 1;
    logic [smsp_pkg::VAL_W-1:0] prev_out  = '0;
    logic [smsp_pkg::VAL_W-1:0] shuf_tab [TAB_DEPTH];

    draw_t pending_draws [$];

    int n_draws    = 0;
    int n_reseeds  = 0;
    int n_results  = 0;
    int n_sat_hits = 0;
    int n_err      = 0;
    int cycle_cnt  = 0;
    int burst_left = 0;

    int hold_reqs  = 0;
    int hold_seen  = 0;
    int hold_left  = 0;
    int phase_left = 0;
    int stall_pct  = 0;

    shuffled_minimal_standard_prng #(
        .TABLE_DEPTH (TAB_DEPTH)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .seed      (seed),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .raw_value (raw_value),
        .fraction  (fraction)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Generator arithmetic
    // ------------------------------------------------------------------
    function automatic logic [smsp_pkg::VAL_W-1:0] mul_mod(input bit [31:0] a,
                                                           input bit [31:0] b);
        bit [63:0]                  prod;
        logic [smsp_pkg::VAL_W-1:0] r;
        prod = 64'(a);
        prod = prod * 64'(b);
        r = smsp_pkg::VAL_W'(prod % 64'(smsp_pkg::LCG_MOD));
        return r;
    endfunction

    function automatic logic [smsp_pkg::VAL_W-1:0] lcg_next(
        input logic [smsp_pkg::VAL_W-1:0] x);
        return mul_mod(32'(x), 32'(smsp_pkg::LCG_MULT));
    endfunction

    function automatic void refill_table(input logic [smsp_pkg::VAL_W-1:0] start);
        logic [smsp_pkg::VAL_W-1:0] x;
        x = start % smsp_pkg::LCG_MOD;
        if (x == '0)
        begin
            x = smsp_pkg::VAL_W'(1);
        end
        for (int i = 0; i < smsp_pkg::WARMUP_STEPS; i++)
        begin
            x = lcg_next(x);
        end
        for (int i = TAB_DEPTH - 1; i >= 0; i--)
        begin
            x = lcg_next(x);
            shuf_tab[i] = x;
        end
        gen_state = x;
        prev_out  = shuf_tab[0];
    endfunction

    function automatic void predict_draw(input logic fn,
                                         input logic [smsp_pkg::VAL_W-1:0] sd,
                                         output logic [smsp_pkg::VAL_W-1:0] raw,
                                         output logic [smsp_pkg::FRAC_W-1:0] frac);
        bit [31:0]                  pos;
        logic [smsp_pkg::VAL_W-1:0] shifted;
        if (fn == OP_RESEED)
        begin
            refill_table(sd);
        end
        else if (prev_out == '0)
        begin
            refill_table(gen_state);
        end
        gen_state = lcg_next(gen_state);
        pos = 32'(prev_out) / SHUF_DIV;
        if (pos >= TAB_DEPTH)
        begin
            pos = 0;
        end
        prev_out = shuf_tab[pos];
        shuf_tab[pos] = gen_state;
        raw = prev_out;
        shifted = prev_out >> 7;
        frac = (shifted > smsp_pkg::VAL_W'(smsp_pkg::FRACTION_MAX)) ?
               smsp_pkg::FRACTION_MAX : shifted[smsp_pkg::FRAC_W-1:0];
    endfunction

    // Seed whose first draw lands in the saturating range: pick the target
    // as the k-th generator value, check that the shuffle index picks it,
    // then step the generator back k times to get the seed.
    function automatic bit find_sat_seed(output logic [smsp_pkg::VAL_W-1:0] s);
        logic [smsp_pkg::VAL_W-1:0] x;
        bit [31:0]                  pos;
        s = smsp_pkg::VAL_W'(1);
        for (int k = smsp_pkg::WARMUP_STEPS + 1;
             k <= smsp_pkg::WARMUP_STEPS + TAB_DEPTH; k++)
        begin
            for (int v = 2147483646; v >= SAT_RAW_MIN; v--)
            begin
                x = smsp_pkg::VAL_W'(v);
                for (int j = k; j < smsp_pkg::WARMUP_STEPS + TAB_DEPTH; j++)
                begin
                    x = lcg_next(x);
                end
                pos = 32'(x) / SHUF_DIV;
                if (pos < TAB_DEPTH && smsp_pkg::WARMUP_STEPS + TAB_DEPTH - pos == k)
                begin
                    s = smsp_pkg::VAL_W'(v);
                    for (int j = 0; j < k; j++)
                    begin
                        s = mul_mod(32'(s), LCG_MULT_INV);
                    end
                    return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    task automatic offer_draw(input logic fn, input logic [smsp_pkg::VAL_W-1:0] sd,
                              input logic chk,
                              input logic [smsp_pkg::FRAC_W-1:0] exp_frac);
        draw_t d;
        in_valid <= 1'b1;
        func     <= fn;
        seed     <= sd;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        predict_draw(fn, sd, d.raw, d.frac);
        if (chk)
        begin
            d.frac = exp_frac;
        end
        pending_draws.push_back(d);
        if (fn == OP_RESEED)
        begin
            n_reseeds++;
        end
        else
        begin
            n_draws++;
        end
    endtask

    // bursts of back-to-back beats, random gaps between bursts
    task automatic pace();
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(24, 1);
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(15, 1);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_draws.size() != 0)
        begin
            @(posedge clk);
        end
        burst_left = 0;
    endtask

    // ------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------
    task automatic mismatch(input string what, input longint exp_v, input longint got_v);
        if (n_err < 10)
        begin
            $display("%s mismatch on result %0d: expected %0d, got %0d",
                     what, n_results, exp_v, got_v);
        end
        n_err++;
    endtask

    always @(posedge clk)
    begin
        if (hold_reqs != hold_seen)
        begin
            hold_seen = hold_reqs;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            if (phase_left == 0)
            begin
                phase_left = $urandom_range(200, 20);
                case ($urandom_range(3))
                    0:       stall_pct = 0;
                    1:       stall_pct = 25;
                    2:       stall_pct = 60;
                    default: stall_pct = 90;
                endcase
            end
            phase_left--;
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        draw_t d;
        if (rst_n && out_valid && !out_stall)
        begin
            n_results++;
            if (fraction == smsp_pkg::FRACTION_MAX)
            begin
                n_sat_hits++;
            end
            if (pending_draws.size() == 0)
            begin
                if (n_err < 10)
                begin
                    $display("Unexpected result beat: raw_value %0d, fraction %0d",
                             raw_value, fraction);
                end
                n_err++;
            end
            else
            begin
                d = pending_draws.pop_front();
                if (raw_value !== d.raw)
                begin
                    mismatch("raw_value", longint'(d.raw), longint'(raw_value));
                end
                if (fraction !== d.frac)
                begin
                    mismatch("fraction", longint'(d.frac), longint'(fraction));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, pending_draws.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        logic [smsp_pkg::VAL_W-1:0] sat_seed;
        logic [smsp_pkg::VAL_W-1:0] sd;
        logic                       fn;
        bit                         sat_ok;
        dir_row_t                   row;

        sat_ok = find_sat_seed(sat_seed);
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIR_N; i++)
        begin
            row = DIR_ROWS[i];
            sd  = row.use_sat ? sat_seed : row.sd;
            pace();
            offer_draw(row.fn, sd, row.chk && (sat_ok || !row.use_sat), row.frac);
        end
        wait_drained();

        for (int i = 0; i < RAND_N; i++)
        begin
            if (i == 300)
            begin
                hold_reqs++;
            end
            if (i == 900)
            begin
                wait_drained();
            end
            pace();
            fn = ($urandom_range(99) < 6) ? OP_RESEED : OP_DRAW;
            case ($urandom_range(19))
                0:       sd = '0;
                1:       sd = '1;
                2:       sd = 31'h7FFF_FFFE;
                default: sd = smsp_pkg::VAL_W'($urandom);
            endcase
            offer_draw(fn, sd, 1'b0, '0);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d draws and %0d reseeds, %0d result beats checked, %0d saturated.",
                 n_draws, n_reseeds, n_results, n_sat_hits);
        $display("Included a %0d-cycle output hold-off and a full drain; %0d mismatches.",
                 HOLD_CYCLES, n_err);
        if (n_err == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hdl/smsp_pkg.sv
hdl/smsp_ram.sv
hdl/shuffled_minimal_standard_prng.sv
verif/tb_shuffled_minimal_standard_prng.sv
